@@ hw/rtl/upd_pkg.sv @@
`timescale 1ns / 1ps
// shared types, character codes and helper functions for the url percent decoder
// no dependencies

package upd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // mode register codes
  localparam logic MODE_FULL       = 1'b0;
  localparam logic MODE_UNRESERVED = 1'b1;

  // register byte offsets (bit 2 of paddr selects the register)
  localparam logic REG_MODE = 1'b0;

  // one decoded group of up to three bytes, last flag applies to the final byte
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            last;
  } upd_cmd_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
      end
      return d[3:0];
    end
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    begin
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E ||
             c == 8'h5F || c == 8'h7E;
    end
  endfunction

endpackage

@@ hw/rtl/upd_front.sv @@
`timescale 1ns / 1ps
// front end: escape tracking and classification of each input byte into a group
// depends on upd_pkg

module upd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              mode,
  output logic              cmd_valid,
  output upd_pkg::upd_cmd_t cmd
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held_digit;
  logic [7:0] plain;
  logic [7:0] value;

  assign plain = (mode == upd_pkg::MODE_FULL && in_byte == upd_pkg::CH_PLUS) ?
                 upd_pkg::CH_SPACE : in_byte;
  assign value = {upd_pkg::hex_value(held_digit), upd_pkg::hex_value(in_byte)};

  always_comb begin
    phase_next = PH_IDLE;
    cmd.count  = 2'd0;
    cmd.bytes  = '0;
    cmd.last   = in_last;
    unique case (phase)
      PH_PCT: begin
        if (in_last) begin
          cmd.count    = 2'd2;
          cmd.bytes[0] = upd_pkg::CH_PERCENT;
          cmd.bytes[1] = plain;
        end else begin
          phase_next = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        if (mode == upd_pkg::MODE_FULL || upd_pkg::is_unreserved(value)) begin
          cmd.count    = 2'd1;
          cmd.bytes[0] = value;
        end else begin
          cmd.count    = 2'd3;
          cmd.bytes[0] = upd_pkg::CH_PERCENT;
          cmd.bytes[1] = held_digit;
          cmd.bytes[2] = in_byte;
        end
      end
      default: begin
        // unused phase code behaves as idle
        if (in_byte == upd_pkg::CH_PERCENT && !in_last) begin
          phase_next = PH_PCT;
        end else begin
          cmd.count    = 2'd1;
          cmd.bytes[0] = plain;
        end
      end
    endcase
  end

  assign cmd_valid = accept && (cmd.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= 8'h00;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == PH_PCT) begin
        held_digit <= in_byte;
      end
    end
  end

endmodule

@@ hw/rtl/upd_queue.sv @@
`timescale 1ns / 1ps
// short register queue of decoded groups between front and back end
// depends on upd_pkg

module upd_queue #(
  parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  upd_pkg::upd_cmd_t push_cmd,
  input  logic              pop,
  output upd_pkg::upd_cmd_t head,
  output logic              empty,
  output logic              full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upd_pkg::upd_cmd_t entries [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/upd_back.sv @@
`timescale 1ns / 1ps
// back end: unpacks each group into single bytes on the output register
// depends on upd_pkg

module upd_back (
  input  logic              clk,
  input  logic              rst,
  input  upd_pkg::upd_cmd_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  logic [1:0] sel;
  logic       load;
  logic       final_byte;
  logic [7:0] pick;

  assign load       = !empty && (!out_valid || !out_stall);
  assign final_byte = (sel == head.count - 2'd1);
  assign pop        = load && final_byte;

  always_comb begin
    case (sel)
      2'd0:    pick = head.bytes[0];
      2'd1:    pick = head.bytes[1];
      default: pick = head.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= final_byte ? 2'd0 : sel + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= pick;
      out_last <= head.last && final_byte;
    end
  end

endmodule

@@ hw/rtl/url_percent_decoder.sv @@
`timescale 1ns / 1ps
// top level of the url percent decoder: mode register, front end, queue, back end
// depends on upd_pkg, upd_front, upd_queue, upd_back
//
// usage
// - input channel in_valid/in_stall carries one encoded byte per transfer with
//   in_last on the final byte of a string; output channel out_valid/out_stall
//   carries one decoded byte per transfer with out_last on the final byte
// - mode register at byte address 0 over the apb-style port: 0 decodes every
//   escape and turns plus into space, 1 decodes only escapes of unreserved chars
// - an input transfer is classified in the cycle it is taken; a decoded group
//   of one to three bytes enters a queue of QUEUE_DEPTH groups, an empty one does not
// - a byte that produces output is written into the queue and from there into
//   the output register that drives out_byte
// - throughput: one input byte per cycle while the queue has room; the back end
//   drains one byte per cycle while out_stall is low, one byte of a three-byte
//   group after another, and a full queue raises in_stall
// - in_stall is high exactly when the queue is full
// - when the receiver stalls, the output register holds its byte and the
//   queue keeps absorbing input until full
// - reset clears the mode to 0, the escape state, the queue and out_valid;
//   write the mode only while the block is idle

module url_percent_decoder #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              mode;
  logic              accept;
  logic              cmd_valid;
  upd_pkg::upd_cmd_t cmd;
  upd_pkg::upd_cmd_t head;
  logic              q_empty;
  logic              q_full;
  logic              q_pop;

  // config port, single register selected by address bit 2
  assign pready = 1'b1;
  assign prdata = (paddr[2] == upd_pkg::REG_MODE) ? {31'b0, mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= upd_pkg::MODE_FULL;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == upd_pkg::REG_MODE) begin
      mode <= pwdata[0];
    end
  end

  // input transfer whenever the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .mode      (mode),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_valid),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

@@ hw/rtl/upd_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the url percent decoder, bound to the top level
// depends on url_percent_decoder

module upd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output changed while stalled");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // a mode write at address 0 reads back on the next cycle
  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr == 3'd0 |=>
      prdata[0] == $past(pwdata[0]))
    else $error("mode write not reflected");

  // only the mode bit is ever nonzero in read data
  a_prdata_upper: assert property (@(posedge clk) disable iff (rst)
    prdata[31:1] == 31'b0)
    else $error("unused read bits set");

  // a full queue always has the output register busy
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid) || out_valid)
    else $error("input stalled with idle output");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);
